### rtl/i2cmra_pkg.sv
// shared types, codes and line-drive helper for the i2c register access master
`default_nettype none
package i2cmra_pkg;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd8;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2, PH_B0, PH_B1, PH_B2,
        PH_A0, PH_A1, PH_A2, PH_A3, PH_T0, PH_T1, PH_T2,
        PH_R0, PH_R1, PH_K0, PH_K1, PH_K2, PH_K3,
        PH_P0, PH_P1, PH_P2, PH_P3
    } t_phase;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_BUS_BUSY   = 3'd1,
        STATUS_START_ERR  = 3'd2,
        STATUS_ADDR_NACK  = 3'd3,
        STATUS_ZERO_COUNT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        STAGE_SLAVE = 2'd0,
        STAGE_REG   = 2'd1,
        STAGE_DATA  = 2'd2
    } t_stage;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic       cmd_valid;
        logic       req_type;
        logic [7:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       rd_last;
        logic       done_res;
        logic [2:0] status;
    } t_out_item;

    // line drive after entering a phase: bit 1 scl, bit 0 sda
    function automatic logic [1:0] enter_drive(
        input t_phase     ph,
        input logic [1:0] cur,
        input logic       shift_msb,
        input logic       bytes_nz
    );
        logic [1:0] d;
        d = cur;
        case (ph)
            PH_S0, PH_T0:                     d = 2'b11;
            PH_S1, PH_S2, PH_T1, PH_T2:       d = 2'b10;
            PH_B1:                            d[0] = shift_msb;
            PH_A1, PH_P3:                     d[0] = 1'b1;
            PH_R0:                            d = 2'b01;
            PH_K1:                            d[0] = ~bytes_nz;
            PH_P1:                            d[0] = 1'b0;
            PH_B2, PH_A2, PH_R1, PH_K2, PH_P2: d[1] = 1'b1;
            default:                          d[1] = 1'b0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### rtl/i2c_master_register_access_core.sv
// top level of the i2c master register read/write engine
// Usage:
//   input channel (i_in_valid/o_in_ready/i_in_data): one word per clock tick of
//   the bus timing, carrying the sampled sda level and optionally a command;
//   commands are taken only while no transaction runs.
//   output channel (o_out_valid/i_out_ready/o_out_data): exactly one word per
//   input word, with scl/sda drive, busy, received bytes and done/status.
//   config channel (i_cfg_valid/o_cfg_ready/i_cfg_data): phase_ticks, always
//   ready; write it only while idle.
// Timing: the result word of an input word is registered and appears in the
//   cycle after it is accepted. Throughput: one word per cycle while the
//   receiver takes them; sequencer state and result register update per word.
// Reset: synchronous, active low; lines released high, sequencer idle,
//   phase_ticks back to 8, no result word pending.
// Stall: when the receiver holds i_out_ready low with a word pending,
//   o_in_ready drops and the sequencer holds its state until the word is taken.
`default_nettype none
module i2c_master_register_access_core #(
    parameter int DELAY_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output wire                   o_in_ready,
    input  i2cmra_pkg::t_in_item  i_in_data,
    output wire                   o_out_valid,
    input  wire                   i_out_ready,
    output i2cmra_pkg::t_out_item o_out_data,
    input  wire                   i_cfg_valid,
    output wire                   o_cfg_ready,
    input  wire  [15:0]           i_cfg_data
);

    logic [15:0]           r_phase_ticks;
    logic                  can_load;
    logic                  step;
    i2cmra_pkg::t_out_item result;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = can_load;
    assign step        = i_in_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cmra_pkg::PHASE_TICKS_RESET;
        end else if (i_cfg_valid) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    i2cmra_fsm #(
        .DELAY_BITS(DELAY_BITS)
    ) u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (i_in_data),
        .i_phase_ticks (r_phase_ticks),
        .o_result      (result)
    );

    i2cmra_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_result    (result),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

### rtl/i2cmra_fsm.sv
// transaction sequencer: advances one tick per accepted word
`default_nettype none
module i2cmra_fsm #(
    parameter int DELAY_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  i2cmra_pkg::t_in_item  i_item,
    input  wire  [15:0]           i_phase_ticks,
    output i2cmra_pkg::t_out_item o_result
);

    localparam int CW = ((DELAY_BITS > 16) ? DELAY_BITS : 16) + 1;
    localparam logic [CW-1:0] DELAY_MAX = (CW'(1) << DELAY_BITS) - CW'(1);

    i2cmra_pkg::t_phase r_phase, n_phase;
    logic [DELAY_BITS-1:0] r_delay, n_delay;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_bytes, n_bytes;
    logic [7:0] r_slave, n_slave;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_data, n_data;
    logic       r_kind, n_kind;
    logic [1:0] r_drive, n_drive;
    i2cmra_pkg::t_stage  r_stage, n_stage;
    i2cmra_pkg::t_status r_err, n_err;

    logic [CW-1:0] pt_raw, pt;
    logic          holding;
    logic [3:0]    bit_inc;
    logic [7:0]    addr_rd;

    always_comb begin
        pt_raw = CW'(i_phase_ticks);
        if (pt_raw == '0) begin
            pt = CW'(1);
        end else if (pt_raw > DELAY_MAX) begin
            pt = DELAY_MAX;
        end else begin
            pt = pt_raw;
        end
        holding = (CW'(r_delay) + CW'(1)) < pt;
        bit_inc = r_bit + 4'd1;
        addr_rd = r_slave + 8'd1;
    end

    // next state
    always_comb begin
        i2cmra_pkg::t_phase tgt;
        logic do_enter;
        tgt      = r_phase;
        do_enter = 1'b0;
        n_phase  = r_phase;
        n_delay  = r_delay;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_bytes  = r_bytes;
        n_slave  = r_slave;
        n_reg    = r_reg;
        n_data   = r_data;
        n_kind   = r_kind;
        n_stage  = r_stage;
        n_err    = r_err;
        n_drive  = r_drive;

        if (r_phase == i2cmra_pkg::PH_IDLE) begin
            if (i_item.cmd_valid) begin
                n_kind  = i_item.req_type;
                n_slave = i_item.slave_address;
                n_reg   = i_item.register_address;
                n_data  = i_item.write_data;
                if (!(i_item.req_type == i2cmra_pkg::REQ_READ && i_item.read_count == 8'd0)) begin
                    n_bytes  = (i_item.req_type == i2cmra_pkg::REQ_READ) ? i_item.read_count : 8'd0;
                    n_stage  = i2cmra_pkg::STAGE_SLAVE;
                    n_bit    = 4'd0;
                    n_err    = i2cmra_pkg::STATUS_OK;
                    tgt      = i2cmra_pkg::PH_S0;
                    do_enter = 1'b1;
                end
            end
        end else if (holding) begin
            n_delay = r_delay + DELAY_BITS'(1);
        end else begin
            case (r_phase)
                i2cmra_pkg::PH_S0: begin
                    if (!i_item.sda_in) n_phase = i2cmra_pkg::PH_IDLE;
                    else begin tgt = i2cmra_pkg::PH_S1; do_enter = 1'b1; end
                end
                i2cmra_pkg::PH_S1: begin
                    if (i_item.sda_in) n_phase = i2cmra_pkg::PH_IDLE;
                    else begin tgt = i2cmra_pkg::PH_S2; do_enter = 1'b1; end
                end
                i2cmra_pkg::PH_S2: begin
                    n_stage = i2cmra_pkg::STAGE_SLAVE; n_shift = r_slave; n_bit = 4'd0;
                    tgt = i2cmra_pkg::PH_B0; do_enter = 1'b1;
                end
                i2cmra_pkg::PH_B0: begin tgt = i2cmra_pkg::PH_B1; do_enter = 1'b1; end
                i2cmra_pkg::PH_B1: begin tgt = i2cmra_pkg::PH_B2; do_enter = 1'b1; end
                i2cmra_pkg::PH_B2: begin
                    n_shift  = {r_shift[6:0], 1'b0};
                    n_bit    = bit_inc;
                    tgt      = (bit_inc >= 4'd8) ? i2cmra_pkg::PH_A0 : i2cmra_pkg::PH_B0;
                    do_enter = 1'b1;
                end
                i2cmra_pkg::PH_A0: begin tgt = i2cmra_pkg::PH_A1; do_enter = 1'b1; end
                i2cmra_pkg::PH_A1: begin tgt = i2cmra_pkg::PH_A2; do_enter = 1'b1; end
                i2cmra_pkg::PH_A2: begin
                    // only the first address byte ack is checked
                    if (r_stage == i2cmra_pkg::STAGE_SLAVE && i_item.sda_in)
                        n_err = i2cmra_pkg::STATUS_ADDR_NACK;
                    tgt = i2cmra_pkg::PH_A3; do_enter = 1'b1;
                end
                i2cmra_pkg::PH_A3: begin
                    do_enter = 1'b1;
                    if (r_err != i2cmra_pkg::STATUS_OK) begin
                        tgt = i2cmra_pkg::PH_P0;
                    end else if (r_stage == i2cmra_pkg::STAGE_SLAVE) begin
                        n_stage = i2cmra_pkg::STAGE_REG; n_shift = r_reg; n_bit = 4'd0;
                        tgt = i2cmra_pkg::PH_B0;
                    end else if (r_stage == i2cmra_pkg::STAGE_REG) begin
                        if (r_kind == i2cmra_pkg::REQ_READ) begin
                            tgt = i2cmra_pkg::PH_T0;
                        end else begin
                            n_stage = i2cmra_pkg::STAGE_DATA; n_shift = r_data; n_bit = 4'd0;
                            tgt = i2cmra_pkg::PH_B0;
                        end
                    end else if (r_kind == i2cmra_pkg::REQ_READ) begin
                        n_bit = 4'd0;
                        tgt   = i2cmra_pkg::PH_R0;
                    end else begin
                        tgt = i2cmra_pkg::PH_P0;
                    end
                end
                i2cmra_pkg::PH_T0: begin
                    do_enter = 1'b1;
                    if (!i_item.sda_in) begin
                        n_stage = i2cmra_pkg::STAGE_DATA; n_shift = addr_rd; n_bit = 4'd0;
                        tgt = i2cmra_pkg::PH_B0;
                    end else begin
                        tgt = i2cmra_pkg::PH_T1;
                    end
                end
                i2cmra_pkg::PH_T1: begin
                    do_enter = 1'b1;
                    if (i_item.sda_in) begin
                        n_stage = i2cmra_pkg::STAGE_DATA; n_shift = addr_rd; n_bit = 4'd0;
                        tgt = i2cmra_pkg::PH_B0;
                    end else begin
                        tgt = i2cmra_pkg::PH_T2;
                    end
                end
                i2cmra_pkg::PH_T2: begin
                    n_stage = i2cmra_pkg::STAGE_DATA; n_shift = addr_rd; n_bit = 4'd0;
                    tgt = i2cmra_pkg::PH_B0; do_enter = 1'b1;
                end
                i2cmra_pkg::PH_R0: begin tgt = i2cmra_pkg::PH_R1; do_enter = 1'b1; end
                i2cmra_pkg::PH_R1: begin
                    n_shift  = {r_shift[6:0], i_item.sda_in};
                    n_bit    = bit_inc;
                    do_enter = 1'b1;
                    if (bit_inc >= 4'd8) begin
                        if (r_bytes != 8'd0) n_bytes = r_bytes - 8'd1;
                        tgt = i2cmra_pkg::PH_K0;
                    end else begin
                        tgt = i2cmra_pkg::PH_R0;
                    end
                end
                i2cmra_pkg::PH_K0: begin tgt = i2cmra_pkg::PH_K1; do_enter = 1'b1; end
                i2cmra_pkg::PH_K1: begin tgt = i2cmra_pkg::PH_K2; do_enter = 1'b1; end
                i2cmra_pkg::PH_K2: begin tgt = i2cmra_pkg::PH_K3; do_enter = 1'b1; end
                i2cmra_pkg::PH_K3: begin
                    do_enter = 1'b1;
                    if (r_bytes != 8'd0) begin
                        n_bit = 4'd0;
                        tgt   = i2cmra_pkg::PH_R0;
                    end else begin
                        tgt = i2cmra_pkg::PH_P0;
                    end
                end
                i2cmra_pkg::PH_P0: begin tgt = i2cmra_pkg::PH_P1; do_enter = 1'b1; end
                i2cmra_pkg::PH_P1: begin tgt = i2cmra_pkg::PH_P2; do_enter = 1'b1; end
                i2cmra_pkg::PH_P2: begin tgt = i2cmra_pkg::PH_P3; do_enter = 1'b1; end
                default: n_phase = i2cmra_pkg::PH_IDLE;
            endcase
        end

        if (do_enter) begin
            n_phase = tgt;
            n_delay = '0;
            n_drive = i2cmra_pkg::enter_drive(tgt, r_drive, n_shift[7], n_bytes != 8'd0);
        end
    end

    // result word
    always_comb begin
        logic timeout;
        timeout  = (r_phase != i2cmra_pkg::PH_IDLE) && !holding;
        o_result = '0;
        o_result.scl_out  = r_drive[1];
        o_result.sda_out  = r_drive[0];
        o_result.busy_res = (n_phase != i2cmra_pkg::PH_IDLE);
        if (r_phase == i2cmra_pkg::PH_IDLE) begin
            if (i_item.cmd_valid && i_item.req_type == i2cmra_pkg::REQ_READ
                && i_item.read_count == 8'd0) begin
                o_result.done_res = 1'b1;
                o_result.status   = i2cmra_pkg::STATUS_ZERO_COUNT;
            end
        end else if (timeout) begin
            case (r_phase)
                i2cmra_pkg::PH_S0: begin
                    if (!i_item.sda_in) begin
                        o_result.done_res = 1'b1;
                        o_result.status   = i2cmra_pkg::STATUS_BUS_BUSY;
                    end
                end
                i2cmra_pkg::PH_S1: begin
                    if (i_item.sda_in) begin
                        o_result.done_res = 1'b1;
                        o_result.status   = i2cmra_pkg::STATUS_START_ERR;
                    end
                end
                i2cmra_pkg::PH_R1: begin
                    if (bit_inc >= 4'd8) begin
                        o_result.rd_valid = 1'b1;
                        o_result.rd_data  = {r_shift[6:0], i_item.sda_in};
                        o_result.rd_last  = (r_bytes <= 8'd1);
                    end
                end
                i2cmra_pkg::PH_P3: begin
                    o_result.done_res = 1'b1;
                    o_result.status   = r_err;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cmra_pkg::PH_IDLE;
            r_delay <= '0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_bytes <= 8'd0;
            r_slave <= 8'd0;
            r_reg   <= 8'd0;
            r_data  <= 8'd0;
            r_kind  <= 1'b0;
            r_drive <= 2'b11;
            r_stage <= i2cmra_pkg::STAGE_SLAVE;
            r_err   <= i2cmra_pkg::STATUS_OK;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_delay <= n_delay;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_bytes <= n_bytes;
            r_slave <= n_slave;
            r_reg   <= n_reg;
            r_data  <= n_data;
            r_kind  <= n_kind;
            r_drive <= n_drive;
            r_stage <= n_stage;
            r_err   <= n_err;
        end
    end

endmodule
`default_nettype wire

### rtl/i2cmra_out_reg.sv
// result register between the sequencer and the output channel
`default_nettype none
module i2cmra_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  i2cmra_pkg::t_out_item i_result,
    output wire                   o_can_load,
    output wire                   o_out_valid,
    input  wire                   i_out_ready,
    output i2cmra_pkg::t_out_item o_out_data
);

    logic                  r_valid;
    i2cmra_pkg::t_out_item r_word;

    // a new word may enter in the same cycle the held one leaves
    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_result;
        end
    end

endmodule
`default_nettype wire

### dv/i2c_txn_scoreboard.sv
// scoreboard class with a bit-exact predictor of the i2c register access master
package i2c_txn_sb_pkg;
    import i2cmra_pkg::*;

    class i2c_txn_scoreboard;
        logic [15:0] phase_ticks;
        t_phase      phase;
        int unsigned delay_count;
        logic [3:0]  bit_count;
        logic [7:0]  shift_reg;
        logic [7:0]  bytes_left;
        logic [7:0]  latched_slave;
        logic [7:0]  latched_register;
        logic [7:0]  latched_data;
        logic        latched_kind;
        logic [1:0]  line_drive;     // bit 1 scl, bit 0 sda
        t_stage      byte_stage;
        t_status     err_code;
        t_out_item   tick_results[$];
        int          errors;
        int          words_checked;

        function new();
            phase_ticks      = PHASE_TICKS_RESET;
            phase            = PH_IDLE;
            delay_count      = 0;
            bit_count        = 4'd0;
            shift_reg        = 8'd0;
            bytes_left       = 8'd0;
            latched_slave    = 8'd0;
            latched_register = 8'd0;
            latched_data     = 8'd0;
            latched_kind     = 1'b0;
            line_drive       = 2'b11;
            byte_stage       = STAGE_SLAVE;
            err_code         = STATUS_OK;
            errors           = 0;
            words_checked    = 0;
        endfunction

        // line levels that hold from the first tick of a phase
        function void go(t_phase p);
            phase       = p;
            delay_count = 0;
            case (p)
                PH_S0, PH_T0:                      line_drive = 2'b11;
                PH_S1, PH_S2, PH_T1, PH_T2:        line_drive = 2'b10;
                PH_B1:                             line_drive[0] = shift_reg[7];
                PH_A1, PH_P3:                      line_drive[0] = 1'b1;
                PH_R0:                             line_drive = 2'b01;
                PH_K1:                             line_drive[0] = (bytes_left == 8'd0);
                PH_P1:                             line_drive[0] = 1'b0;
                PH_B2, PH_A2, PH_R1, PH_K2, PH_P2: line_drive[1] = 1'b1;
                default:                           line_drive[1] = 1'b0;
            endcase
        endfunction

        function void load_byte(t_stage stage, logic [7:0] value);
            byte_stage = stage;
            shift_reg  = value;
            bit_count  = 4'd0;
            go(PH_B0);
        endfunction

        function t_out_item advance_tick(t_in_item w);
            t_out_item   r;
            int unsigned pt;
            logic [7:0]  addr_rd;
            r = '0;
            pt = 32'(phase_ticks);
            if (pt == 0) pt = 1;
            r.scl_out = line_drive[1];
            r.sda_out = line_drive[0];
            if (phase == PH_IDLE) begin
                if (w.cmd_valid) begin
                    latched_kind     = w.req_type;
                    latched_slave    = w.slave_address;
                    latched_register = w.register_address;
                    latched_data     = w.write_data;
                    if (w.req_type == REQ_READ && w.read_count == 8'd0) begin
                        r.done_res = 1'b1;
                        r.status   = STATUS_ZERO_COUNT;
                    end else begin
                        bytes_left = (w.req_type == REQ_READ) ? w.read_count : 8'd0;
                        byte_stage = STAGE_SLAVE;
                        bit_count  = 4'd0;
                        err_code   = STATUS_OK;
                        go(PH_S0);
                    end
                end
            end else if (delay_count + 1 < pt) begin
                delay_count = delay_count + 1;
            end else begin
                addr_rd = latched_slave + 8'd1;
                case (phase)
                    PH_S0: begin
                        if (!w.sda_in) begin
                            phase      = PH_IDLE;
                            r.done_res = 1'b1;
                            r.status   = STATUS_BUS_BUSY;
                        end else go(PH_S1);
                    end
                    PH_S1: begin
                        if (w.sda_in) begin
                            phase      = PH_IDLE;
                            r.done_res = 1'b1;
                            r.status   = STATUS_START_ERR;
                        end else go(PH_S2);
                    end
                    PH_S2: load_byte(STAGE_SLAVE, latched_slave);
                    PH_B0: go(PH_B1);
                    PH_B1: go(PH_B2);
                    PH_B2: begin
                        shift_reg = {shift_reg[6:0], 1'b0};
                        bit_count = bit_count + 4'd1;
                        go(bit_count >= 4'd8 ? PH_A0 : PH_B0);
                    end
                    PH_A0: go(PH_A1);
                    PH_A1: go(PH_A2);
                    PH_A2: begin
                        // only the address slot is checked
                        if (byte_stage == STAGE_SLAVE && w.sda_in) err_code = STATUS_ADDR_NACK;
                        go(PH_A3);
                    end
                    PH_A3: begin
                        if (err_code != STATUS_OK) go(PH_P0);
                        else if (byte_stage == STAGE_SLAVE) load_byte(STAGE_REG, latched_register);
                        else if (byte_stage == STAGE_REG) begin
                            if (latched_kind == REQ_READ) go(PH_T0);
                            else load_byte(STAGE_DATA, latched_data);
                        end else if (latched_kind == REQ_READ) begin
                            bit_count = 4'd0;
                            go(PH_R0);
                        end else go(PH_P0);
                    end
                    // repeated start may shortcut on odd sda levels
                    PH_T0: begin
                        if (!w.sda_in) load_byte(STAGE_DATA, addr_rd);
                        else go(PH_T1);
                    end
                    PH_T1: begin
                        if (w.sda_in) load_byte(STAGE_DATA, addr_rd);
                        else go(PH_T2);
                    end
                    PH_T2: load_byte(STAGE_DATA, addr_rd);
                    PH_R0: go(PH_R1);
                    PH_R1: begin
                        shift_reg = {shift_reg[6:0], w.sda_in};
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= 4'd8) begin
                            r.rd_valid = 1'b1;
                            r.rd_data  = shift_reg;
                            r.rd_last  = (bytes_left <= 8'd1);
                            if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
                            go(PH_K0);
                        end else go(PH_R0);
                    end
                    PH_K0: go(PH_K1);
                    PH_K1: go(PH_K2);
                    PH_K2: go(PH_K3);
                    PH_K3: begin
                        if (bytes_left != 8'd0) begin
                            bit_count = 4'd0;
                            go(PH_R0);
                        end else go(PH_P0);
                    end
                    PH_P0: go(PH_P1);
                    PH_P1: go(PH_P2);
                    PH_P2: go(PH_P3);
                    PH_P3: begin
                        phase      = PH_IDLE;
                        r.done_res = 1'b1;
                        r.status   = err_code;
                    end
                    default: phase = PH_IDLE;
                endcase
            end
            r.busy_res = (phase != PH_IDLE);
            return r;
        endfunction

        function void accept_tick(t_in_item w);
            tick_results.push_back(advance_tick(w));
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t, word %0d: %s", $time, words_checked, msg);
        endtask

        task check_word(t_out_item got);
            t_out_item want;
            if (tick_results.size() == 0) begin
                report($sformatf("word %h with nothing pending", got));
            end else begin
                want = tick_results.pop_front();
                if (got.scl_out !== want.scl_out)
                    report($sformatf("scl_out %b want %b", got.scl_out, want.scl_out));
                if (got.sda_out !== want.sda_out)
                    report($sformatf("sda_out %b want %b", got.sda_out, want.sda_out));
                if (got.busy_res !== want.busy_res)
                    report($sformatf("busy_res %b want %b", got.busy_res, want.busy_res));
                if (got.rd_valid !== want.rd_valid)
                    report($sformatf("rd_valid %b want %b", got.rd_valid, want.rd_valid));
                if (got.rd_data !== want.rd_data)
                    report($sformatf("rd_data %h want %h", got.rd_data, want.rd_data));
                if (got.rd_last !== want.rd_last)
                    report($sformatf("rd_last %b want %b", got.rd_last, want.rd_last));
                if (got.done_res !== want.done_res)
                    report($sformatf("done_res %b want %b", got.done_res, want.done_res));
                if (got.status !== want.status)
                    report($sformatf("status %0d want %0d", got.status, want.status));
            end
            words_checked++;
        endtask
    endclass

endpackage

### dv/tb_top.sv
// testbench top: drives bus ticks, commands and phase_ticks, checks every result word
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmra_pkg::*;
    import i2c_txn_sb_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int ITEMS_TARGET = 1650;

    // how the simulated slave and bus behave during one transaction
    typedef enum {
        FAULT_NONE, FAULT_GLITCH, FAULT_NOISE, FAULT_BUS_BUSY, FAULT_START_ERR,
        FAULT_ADDR_NACK, FAULT_RS_LOW, FAULT_RS_HIGH
    } t_fault;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_word   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'd0;

    i2c_txn_scoreboard sb;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int rx_hold_cycles = 0;
    int items_sent    = 0;
    int stuck_cycles  = 0;

    always #5 clk = ~clk;

    i2c_master_register_access_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // sda level seen by the master: its own drive, overridden by the slave and the fault
    function automatic logic bus_sda(t_fault f);
        logic lvl;
        if (f == FAULT_NOISE) return ($urandom_range(0, 1) != 0);
        lvl = sb.line_drive[0];
        case (sb.phase)
            PH_S0: if (f == FAULT_BUS_BUSY) lvl = 1'b0;
            PH_S1: if (f == FAULT_START_ERR) lvl = 1'b1;
            PH_T0: if (f == FAULT_RS_LOW) lvl = 1'b0;
            PH_T1: if (f == FAULT_RS_HIGH) lvl = 1'b1;
            PH_A0, PH_A1, PH_A2, PH_A3: begin
                if (!(f == FAULT_ADDR_NACK && sb.byte_stage == STAGE_SLAVE)) lvl = 1'b0;
            end
            PH_R0, PH_R1: lvl = ($urandom_range(0, 1) != 0);
            default: ;
        endcase
        if (f == FAULT_GLITCH && $urandom_range(0, 7) == 0) lvl = ~lvl;
        return lvl;
    endfunction

    function automatic t_in_item filler_word();
        t_in_item w;
        w.cmd_valid        = 1'b0;
        w.req_type         = ($urandom_range(0, 1) != 0);
        w.slave_address    = 8'($urandom);
        w.register_address = 8'($urandom);
        w.write_data       = 8'($urandom);
        w.read_count       = 8'($urandom);
        w.sda_in           = ($urandom_range(0, 1) != 0);
        return w;
    endfunction

    function automatic t_in_item make_cmd(logic kind, logic [7:0] slave, logic [7:0] regad,
                                          logic [7:0] data, logic [7:0] count);
        t_in_item w;
        w = filler_word();
        w.cmd_valid        = 1'b1;
        w.req_type         = kind;
        w.slave_address    = slave;
        w.register_address = regad;
        w.write_data       = data;
        w.read_count       = count;
        return w;
    endfunction

    task automatic send_word(input t_in_item w);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sb.accept_tick(w);
        items_sent++;
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_word(filler_word());
    endtask

    // one command word, then bus ticks until the transaction is over
    task automatic run_txn(input t_in_item cmd, input t_fault f, input bit poke_busy);
        t_in_item w;
        send_word(cmd);
        while (sb.phase != PH_IDLE) begin
            w = filler_word();
            w.cmd_valid = poke_busy && ($urandom_range(0, 15) == 0);
            w.sda_in    = bus_sda(f);
            send_word(w);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.tick_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_phase_ticks(input logic [15:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.phase_ticks = v;
    endtask

    // result side
    initial begin
        t_out_item got;
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 99) == 0) rx_idle_on = !rx_idle_on;
            if (rx_hold_cycles != 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else stall = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            got = out_word;
            @(posedge clk);
            sb.check_word(got);
        end
    end

    always @(negedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int     group_left;
        int     pick;
        logic   kind;
        logic [7:0] count;
        t_fault f;

        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, first transaction at the reset phase_ticks
        run_txn(make_cmd(REQ_WRITE, 8'h00, 8'hFF, 8'hA5, 8'h00), FAULT_START_ERR, 1'b0);
        set_phase_ticks(16'd1);
        run_txn(make_cmd(REQ_WRITE, 8'hFF, 8'h00, 8'h00, 8'hFF), FAULT_NONE, 1'b1);
        // read address wraps from ff to 00
        run_txn(make_cmd(REQ_READ, 8'hFF, 8'h12, 8'h00, 8'h01), FAULT_NONE, 1'b0);
        run_txn(make_cmd(REQ_READ, 8'hA0, 8'h34, 8'h00, 8'h02), FAULT_NONE, 1'b1);
        run_txn(make_cmd(REQ_READ, 8'hA0, 8'h00, 8'hFF, 8'h00), FAULT_NONE, 1'b0);
        run_txn(make_cmd(REQ_WRITE, 8'h40, 8'h01, 8'h80, 8'h00), FAULT_ADDR_NACK, 1'b0);
        run_txn(make_cmd(REQ_READ, 8'h41, 8'h7F, 8'h01, 8'h02), FAULT_ADDR_NACK, 1'b0);
        run_txn(make_cmd(REQ_WRITE, 8'h22, 8'h33, 8'h44, 8'h00), FAULT_BUS_BUSY, 1'b0);
        run_txn(make_cmd(REQ_READ, 8'h22, 8'h33, 8'h44, 8'h02), FAULT_START_ERR, 1'b0);
        run_txn(make_cmd(REQ_READ, 8'hD0, 8'h0F, 8'h00, 8'h01), FAULT_RS_LOW, 1'b0);
        run_txn(make_cmd(REQ_READ, 8'hD0, 8'hF0, 8'h00, 8'h01), FAULT_RS_HIGH, 1'b0);
        idle_ticks(3);
        // zero phase_ticks behaves as one
        set_phase_ticks(16'd0);
        run_txn(make_cmd(REQ_READ, 8'h3D, 8'h55, 8'hAA, 8'h01), FAULT_GLITCH, 1'b0);
        // largest phase: only a rejected read, which never leaves idle
        set_phase_ticks(16'hFFFF);
        tx_idle_on = 1'b0;
        run_txn(make_cmd(REQ_READ, 8'h10, 8'h20, 8'h30, 8'h00), FAULT_NONE, 1'b0);
        idle_ticks(2);
        tx_idle_on = 1'b1;

        // random part, opens with a long receiver hold that stalls the input side
        set_phase_ticks(16'd1);
        rx_hold_cycles = 300;
        group_left = 3;
        while (items_sent < ITEMS_TARGET) begin
            if (group_left == 0) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       set_phase_ticks(16'd0);
                    7, 8:    set_phase_ticks(16'd2);
                    9:       set_phase_ticks(16'($urandom_range(3, 4)));
                    default: set_phase_ticks(16'd1);
                endcase
                group_left = 3;
                tx_idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 3) == 0) rx_hold_cycles = $urandom_range(50, 300);
            end
            kind = ($urandom_range(0, 1) != 0);
            pick = $urandom_range(0, 31);
            if (kind == REQ_WRITE) count = 8'($urandom);
            else if (pick == 0) count = 8'd0;
            else if (pick == 1) count = 8'($urandom_range(3, 4));
            else count = 8'($urandom_range(1, 2));
            pick = $urandom_range(0, 19);
            case (pick)
                10, 11:  f = FAULT_GLITCH;
                12, 13:  f = FAULT_NOISE;
                14:      f = FAULT_BUS_BUSY;
                15:      f = FAULT_START_ERR;
                16:      f = FAULT_ADDR_NACK;
                17:      f = FAULT_RS_LOW;
                18:      f = FAULT_RS_HIGH;
                default: f = FAULT_NONE;
            endcase
            run_txn(make_cmd(kind, 8'($urandom), 8'($urandom), 8'($urandom), count), f,
                    $urandom_range(0, 3) == 0);
            idle_ticks($urandom_range(0, 3));
            group_left--;
        end

        settle();
        if (sb.errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
